// ----- sv/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and codes for the sequence store with search: the request and
// result structs, operation codes and status codes.
// ----------------------------------------------------------------------------
package sss_pkg;

    // Field widths fixed by the interface
    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int ST_W  = 3;
    localparam int ECW   = 6;

    // Most results reported for one find
    localparam int MAX_RESULTS = 32;
    localparam int NEMIT_W     = $clog2(MAX_RESULTS);

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND     = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;

    // Request payload
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] match_position;
        logic [ECW-1:0]   entry_count;
        logic             last;
    } t_rsp;

endpackage

// ----- sv/sequence_store_with_search.sv -----
// ----------------------------------------------------------------------------
// sequence_store_with_search
// Ordered store of up to CAPACITY signed words with append, delete and a
// find that reports every matching position.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Append, delete tail,
// errors, unused opcodes and deletes of the final entry finish in the idle
// state, and busy stays low, so such requests can follow each other every
// cycle. Delete head and delete at position move every later entry down one
// place through the entry memory's write port and registered read port, one
// entry per cycle, and busy stays high until the last entry has moved. Find
// reads the memory one entry per cycle: busy stays high until the scan reaches
// the end or the result limit, and through the flush state when the final
// match needs its own result. Results appear on o_rsp from a result register,
// at most one per cycle and marked by o_valid; they cannot be held off, so take
// them as they come. The final result of a request carries last.
module sequence_store_with_search #(
    parameter int CAPACITY = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sss_pkg::t_req  i_req,
    output logic           o_valid,
    output sss_pkg::t_rsp  o_rsp
);
    import sss_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FIND  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_ptr, n_ptr;
    logic [VAL_W-1:0]   r_val, n_val;
    logic               r_pend_vld, n_pend_vld;
    logic [IW-1:0]      r_pend_pos, n_pend_pos;
    logic [NEMIT_W-1:0] r_nemit, n_nemit;
    logic               r_valid, n_valid;
    t_rsp               r_rsp, n_rsp;
    logic [VAL_W-1:0]   r_rd_data;

    logic [VAL_W-1:0]   mem [CAPACITY];

    logic               wr_en, rd_en;
    logic [IW-1:0]      wr_addr, rd_addr;
    logic [VAL_W-1:0]   wr_data;

    logic               accept;
    logic               emit, emit_last;
    logic [ST_W-1:0]    emit_status;
    logic [IW-1:0]      emit_pos;
    logic               del_go;
    logic [IW-1:0]      del_idx;
    logic               hit, at_end, shift_end;

    assign accept = start && (r_state == S_IDLE);
    assign hit    = (r_rd_data == r_val);
    assign at_end = (XW'(r_ptr) + XW'(1)) == XW'(r_count);
    assign shift_end = (XW'(r_ptr) + XW'(2)) == XW'(r_count);

    // Sequencer and datapath control
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_val      = r_val;
        n_pend_vld = r_pend_vld;
        n_pend_pos = r_pend_pos;
        n_nemit    = r_nemit;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;
        wr_en      = 1'b0;
        wr_addr    = r_ptr;
        wr_data    = r_rd_data;
        rd_en      = 1'b0;
        rd_addr    = r_ptr;
        emit       = 1'b0;
        emit_last  = 1'b1;
        emit_status = ST_DONE;
        emit_pos   = '0;
        del_go     = 1'b0;
        del_idx    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    emit = 1'b1;
                    unique case (i_req.operation)
                        OP_APPEND: begin
                            if (XW'(r_count) == XW'(CAPACITY)) begin
                                emit_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[IW-1:0];
                                wr_data = i_req.value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_DEL_HEAD: begin
                            if (r_count == '0) begin
                                emit_status = ST_EMPTY;
                            end else begin
                                del_go = 1'b1;
                            end
                        end
                        OP_DEL_TAIL: begin
                            if (r_count == '0) begin
                                emit_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_DEL_POS: begin
                            if (r_count == '0) begin
                                emit_status = ST_EMPTY;
                            end else if (XW'(i_req.position) >= XW'(r_count)) begin
                                emit_status = ST_RANGE;
                            end else begin
                                del_go  = 1'b1;
                                del_idx = IW'(i_req.position);
                            end
                        end
                        OP_FIND: begin
                            if (r_count == '0) begin
                                emit_status = ST_EMPTY;
                            end else begin
                                emit       = 1'b0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                n_ptr      = '0;
                                n_val      = i_req.value;
                                n_pend_vld = 1'b0;
                                n_nemit    = '0;
                                n_state    = S_FIND;
                            end
                        end
                        default: begin
                            emit_status = ST_DONE;
                        end
                    endcase

                    // Delete: drop the final entry directly, else move later ones down
                    if (del_go) begin
                        if ((XW'(del_idx) + XW'(1)) == XW'(r_count)) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            emit    = 1'b0;
                            rd_en   = 1'b1;
                            rd_addr = IW'(XW'(del_idx) + XW'(1));
                            n_ptr   = del_idx;
                            n_state = S_SHIFT;
                        end
                    end
                end
            end

            // Move entry ptr+1 to ptr, one per cycle
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = r_rd_data;
                if (shift_end) begin
                    n_count = r_count - CW'(1);
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(XW'(r_ptr) + XW'(2));
                    n_ptr   = IW'(XW'(r_ptr) + XW'(1));
                end
            end

            // Scan: one match is held back so the final one can carry last
            S_FIND: begin
                if (!at_end) begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(XW'(r_ptr) + XW'(1));
                    n_ptr   = IW'(XW'(r_ptr) + XW'(1));
                end
                if (hit) begin
                    if (r_pend_vld) begin
                        emit        = 1'b1;
                        emit_last   = 1'b0;
                        emit_status = ST_FOUND;
                        emit_pos    = r_pend_pos;
                        n_nemit     = r_nemit + NEMIT_W'(1);
                        n_pend_pos  = r_ptr;
                        if (at_end || r_nemit == NEMIT_W'(MAX_RESULTS - 2)) begin
                            n_state = S_FLUSH;
                        end
                    end else if (at_end) begin
                        emit        = 1'b1;
                        emit_status = ST_FOUND;
                        emit_pos    = r_ptr;
                        n_state     = S_IDLE;
                    end else begin
                        n_pend_vld = 1'b1;
                        n_pend_pos = r_ptr;
                    end
                end else if (at_end) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_pend_vld) begin
                        emit_status = ST_FOUND;
                        emit_pos    = r_pend_pos;
                    end else begin
                        emit_status = ST_NOTFOUND;
                    end
                end
            end

            // Final held match
            S_FLUSH: begin
                emit        = 1'b1;
                emit_status = ST_FOUND;
                emit_pos    = r_pend_pos;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Result register load
        if (emit) begin
            n_valid              = 1'b1;
            n_rsp.status         = emit_status;
            n_rsp.match_position = POS_W'(emit_pos);
            n_rsp.entry_count    = ECW'(n_count);
            n_rsp.last           = emit_last;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pend_vld <= 1'b0;
            r_nemit    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            r_nemit    <= n_nemit;
            r_valid    <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_val      <= n_val;
        r_pend_pos <= n_pend_pos;
        r_rsp      <= n_rsp;
    end

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(CAPACITY))
        else $error("entry count above capacity");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.operation == OP_APPEND && XW'(r_count) < XW'(CAPACITY))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the store");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rsp.last) |-> (r_state == S_IDLE))
        else $error("final result while sequencer still busy");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_rsp.last) |-> (r_state == S_FIND || r_state == S_FLUSH))
        else $error("non-final result outside a find");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sequence_store_with_search. A queue of requests is
// built up front: a directed opening (empty store, spare opcodes, extreme
// values, range errors, multi-match finds), then random traffic with a full
// fill-to-capacity pass. The driver issues requests with random idle bursts.
// The monitor checks every result against a local model of the store.
// ----------------------------------------------------------------------------
module testbench;

    import sss_pkg::*;

    localparam int STORE_DEPTH    = 32;
    localparam int QUIET_TAIL     = 30;    // final requests sent back to back
    localparam int SETTLE_CYCLES  = STORE_DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 1000;

    // Opcodes the block does not use; they must answer done
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        t_req req;
        bit   drain;    // hold this request until every result is back
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    // Local copy of the store
    logic signed [VAL_W-1:0] store_words [STORE_DEPTH];
    int                      store_count = 0;

    t_pending pending_requests [$];
    t_rsp     results_due      [$];
    int       gen_count   = 0;     // entry count as the request list is built
    int       n_items     = 0;
    int       sent_items  = 0;
    int       gap_left    = 0;
    int       mismatches  = 0;
    int       idle_cycles = 0;

    sequence_store_with_search #(
        .CAPACITY(STORE_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the local store and queue the results it causes
    function automatic void predict_request(input t_req r);
        t_rsp rsp;
        int   drop_at;
        int   hits;
        int   emitted;
        drop_at = -1;
        hits    = 0;
        emitted = 0;
        rsp     = '0;
        rsp.status = ST_DONE;
        rsp.last   = 1'b1;
        case (r.operation)
            OP_APPEND: begin
                if (store_count >= STORE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    store_words[store_count] = r.value;
                    store_count++;
                end
            end
            OP_DEL_HEAD: begin
                if (store_count == 0) rsp.status = ST_EMPTY;
                else drop_at = 0;
            end
            OP_DEL_TAIL: begin
                if (store_count == 0) rsp.status = ST_EMPTY;
                else store_count--;
            end
            OP_DEL_POS: begin
                if (store_count == 0) rsp.status = ST_EMPTY;
                else if (int'(r.position) >= store_count) rsp.status = ST_RANGE;
                else drop_at = int'(r.position);
            end
            OP_FIND: begin
                if (store_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < store_count; i++)
                        if (store_words[i] == r.value) hits++;
                    if (hits == 0) rsp.status = ST_NOTFOUND;
                    if (hits > MAX_RESULTS) hits = MAX_RESULTS;
                end
            end
            default: ;
        endcase

        // Close the gap left by a delete
        if (drop_at >= 0) begin
            for (int i = drop_at; i + 1 < store_count; i++)
                store_words[i] = store_words[i + 1];
            store_count--;
        end

        if (hits > 0) begin
            // One result per match, ascending position
            for (int i = 0; i < store_count && emitted < hits; i++) begin
                if (store_words[i] == r.value) begin
                    rsp.status         = ST_FOUND;
                    rsp.match_position = POS_W'(i);
                    rsp.entry_count    = ECW'(store_count);
                    rsp.last           = (emitted == hits - 1);
                    results_due.push_back(rsp);
                    emitted++;
                end
            end
        end else begin
            rsp.entry_count = ECW'(store_count);
            results_due.push_back(rsp);
        end
    endfunction

    // Queue a request and follow the entry count it leaves behind
    function automatic void add_request(input logic [OP_W-1:0] op,
                                        input logic signed [VAL_W-1:0] val,
                                        input logic [POS_W-1:0] pos,
                                        input bit drain);
        t_pending p;
        p.req.operation = op;
        p.req.value     = val;
        p.req.position  = pos;
        p.drain         = drain;
        pending_requests.push_back(p);
        case (op)
            OP_APPEND:   if (gen_count < STORE_DEPTH) gen_count++;
            OP_DEL_HEAD,
            OP_DEL_TAIL: if (gen_count > 0) gen_count--;
            OP_DEL_POS:  if (int'(pos) < gen_count) gen_count--;
            default: ;
        endcase
    endfunction

    // Mostly a small pool so finds hit; sometimes a full random word
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh0000_0000;
            1:       return -32'sd1;
            2:       return 32'sh8000_0000;
            3:       return 32'sh7FFF_FFFF;
            4:       return 32'sd7;
            5:       return 32'sd42;
            6:       return -32'sd42;
            7:       return 32'sd1000;
            default: return $urandom;
        endcase
    endfunction

    // Position: usually inside the store, sometimes anywhere
    function automatic logic [POS_W-1:0] pick_position();
        if (gen_count > 0 && $urandom_range(0, 2) != 0)
            return POS_W'($urandom_range(0, gen_count - 1));
        return POS_W'($urandom_range(0, 31));
    endfunction

    // Random request mix
    function automatic void add_random_requests(input int n);
        int pick;
        logic [OP_W-1:0] op;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      op = OP_APPEND;
            else if (pick < 50) op = OP_DEL_HEAD;
            else if (pick < 60) op = OP_DEL_TAIL;
            else if (pick < 72) op = OP_DEL_POS;
            else if (pick < 95) op = OP_FIND;
            else begin
                case ($urandom_range(0, 2))
                    0:       op = OP_SPARE_5;
                    1:       op = OP_SPARE_6;
                    default: op = OP_SPARE_7;
                endcase
            end
            add_request(op, pick_value(), pick_position(), $urandom_range(0, 19) == 0);
        end
    endfunction

    // Request driver
    always @(posedge i_clk) begin : drive_requests
        t_pending nxt;
        logic     taken;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            taken = start && !busy;
            if (taken) predict_request(i_req);
            if (!start || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_requests.size() != 0 &&
                             !(pending_requests[0].drain && results_due.size() != 0)) begin
                    nxt = pending_requests.pop_front();
                    i_req <= nxt.req;
                    start <= 1'b1;
                    sent_items++;
                    if (sent_items < n_items - QUIET_TAIL && $urandom_range(0, 2) == 0)
                        gap_left = $urandom_range(1, 11);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Field check, reports only a difference
    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    // Result monitor
    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_rsp);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (o_rsp !== want) mismatches++;
                compare_field("status", 32'(want.status), 32'(o_rsp.status));
                compare_field("match_position", 32'(want.match_position),
                              32'(o_rsp.match_position));
                compare_field("entry_count", 32'(want.entry_count),
                              32'(o_rsp.entry_count));
                compare_field("last", 32'(want.last), 32'(o_rsp.last));
            end
        end
    end

    // Watchdog: too long with neither a request nor a result taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no progress", $time);
                $display("** sequence_store_with_search: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial begin : run_test
        logic signed [VAL_W-1:0] fill_val;

        // Empty store, spare opcodes
        add_request(OP_FIND,     32'sd0, 5'd0, 1'b0);
        add_request(OP_DEL_HEAD, 32'sd0, 5'd0, 1'b0);
        add_request(OP_DEL_TAIL, 32'sd0, 5'd0, 1'b0);
        add_request(OP_DEL_POS,  32'sd0, 5'd0, 1'b0);
        add_request(OP_SPARE_5,  32'sh7FFF_FFFF, 5'd0, 1'b0);
        add_request(OP_SPARE_6,  32'sh8000_0000, 5'd15, 1'b0);
        add_request(OP_SPARE_7,  -32'sd1, 5'd31, 1'b0);
        // Extremes, with a repeated value for a double match
        add_request(OP_APPEND, 32'sh8000_0000, 5'd0, 1'b0);
        add_request(OP_APPEND, 32'sh7FFF_FFFF, 5'd31, 1'b0);
        add_request(OP_APPEND, 32'sd0, 5'd0, 1'b0);
        add_request(OP_APPEND, -32'sd1, 5'd0, 1'b0);
        add_request(OP_APPEND, 32'sh8000_0000, 5'd0, 1'b0);
        add_request(OP_FIND,   32'sh8000_0000, 5'd0, 1'b0);
        add_request(OP_FIND,   32'sd12345, 5'd0, 1'b0);
        // Position out of range, then each kind of delete
        add_request(OP_DEL_POS,  32'sd0, 5'd31, 1'b0);
        add_request(OP_DEL_POS,  32'sd0, 5'd5, 1'b0);
        add_request(OP_DEL_POS,  32'sd0, 5'd2, 1'b0);
        add_request(OP_DEL_HEAD, 32'sd0, 5'd0, 1'b0);
        add_request(OP_DEL_TAIL, 32'sd0, 5'd0, 1'b0);
        add_request(OP_FIND,     32'sh7FFF_FFFF, 5'd0, 1'b0);
        add_request(OP_FIND,     -32'sd1, 5'd0, 1'b0);

        // Random mix, starting from a drained pipeline
        add_request(OP_APPEND, pick_value(), pick_position(), 1'b1);
        add_random_requests(70);

        // Empty the store, fill it with one value, then append three more past capacity
        add_request(OP_DEL_TAIL, 32'sd0, 5'd0, 1'b1);
        while (gen_count > 0) begin
            case ($urandom_range(0, 2))
                0:       add_request(OP_DEL_HEAD, pick_value(), pick_position(), 1'b0);
                1:       add_request(OP_DEL_TAIL, pick_value(), pick_position(), 1'b0);
                default: add_request(OP_DEL_POS, pick_value(),
                                     POS_W'($urandom_range(0, gen_count - 1)), 1'b0);
            endcase
        end
        fill_val = pick_value();
        for (int k = 0; k < STORE_DEPTH; k++)
            add_request(OP_APPEND, fill_val, POS_W'($urandom), 1'b0);
        for (int k = 0; k < 3; k++)
            add_request(OP_APPEND, pick_value(), POS_W'($urandom), 1'b0);
        add_request(OP_FIND, fill_val, 5'd0, 1'b0);
        add_request(OP_FIND, pick_value(), 5'd0, 1'b0);
        add_request(OP_DEL_POS, 32'sd0, POS_W'($urandom_range(0, 31)), 1'b0);
        add_request(OP_FIND, fill_val, 5'd0, 1'b1);

        // Tail of random traffic, sent without idle gaps
        add_random_requests(QUIET_TAIL - 5);
        n_items = pending_requests.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("** sequence_store_with_search: PASSED **");
        else
            $display("** sequence_store_with_search: FAILED **");
        $finish;
    end

endmodule
